[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent checks clocked on clk, quiet while rst_n is low
`define QECC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qecc check failed");

`define QECC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qecc check failed");

`endif

[hw/rtl/qecc_pkg.sv]
package qecc_pkg;

    localparam int ANG_W    = 34;
    localparam int VX_W     = 36;
    localparam int RX_W     = 42;
    localparam int SQ_STEPS = 31;
    localparam int SQ_W     = 61;
    localparam int SQ_RW    = SQ_W + 1;

    localparam logic [29:0] KINV_Q30 = 30'd652032874;
    localparam logic signed [VX_W-1:0]  ONE_Q30     = VX_W'(1) <<< 30;
    localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(1) <<< 31;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(1) <<< 30;

    typedef enum logic [1:0] {
        REG_FOLLOW   = 2'd0,
        REG_MIN_H    = 2'd1,
        REG_FALLBACK = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    typedef struct packed {
        logic signed [31:0] zy;
        logic signed [31:0] wx;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zw;
        logic signed [31:0] xy;
        logic signed [31:0] zz;
        logic signed [31:0] yw;
        logic signed [31:0] zx;
    } prod_t;

    typedef struct packed {
        logic signed [VX_W-1:0]  x;
        logic signed [VX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [RX_W-1:0]  x;
        logic signed [RX_W-1:0]  y;
        logic signed [ANG_W-1:0] a;
    } rot_t;

    typedef struct packed {
        logic [SQ_W-1:0]  rem;
        logic [SQ_RW-1:0] res;
    } sq_t;

    typedef struct packed {
        pos_t               pos;
        vec_t               rv;
        vec_t               yv;
        logic signed [31:0] s;
    } sqc_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_ang(input int i);
        logic [29:0] r;
        case (i)
            0:  r = 30'd536870912;
            1:  r = 30'd316933406;
            2:  r = 30'd167458907;
            3:  r = 30'd85004756;
            4:  r = 30'd42667331;
            5:  r = 30'd21354465;
            6:  r = 30'd10679838;
            7:  r = 30'd5340245;
            8:  r = 30'd2670163;
            9:  r = 30'd1335087;
            10: r = 30'd667544;
            11: r = 30'd333772;
            12: r = 30'd166886;
            13: r = 30'd83443;
            14: r = 30'd41722;
            15: r = 30'd20861;
            16: r = 30'd10430;
            17: r = 30'd5215;
            18: r = 30'd2608;
            19: r = 30'd1304;
            20: r = 30'd652;
            21: r = 30'd326;
            22: r = 30'd163;
            23: r = 30'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // vectoring: drive y toward zero, angle gathers in z
    function automatic vec_t vec_step(input vec_t v, input int i);
        vec_t r;
        logic signed [VX_W-1:0]  xs;
        logic signed [VX_W-1:0]  ys;
        logic signed [ANG_W-1:0] a;
        r  = v;
        xs = v.x >>> i;
        ys = v.y >>> i;
        a  = ANG_W'(signed'({1'b0, atan_ang(i)}));
        if (v.y > 0)
        begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + a;
        end
        else if (v.y < 0)
        begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - a;
        end
        return r;
    endfunction

    // half-turn pre-rotation for a negative x term
    function automatic vec_t vec_prerot(input vec_t v);
        vec_t r;
        r = v;
        if (v.x < 0)
        begin
            r.z = (v.y >= 0) ? ANG_PI : -ANG_PI;
            r.x = -v.x;
            r.y = -v.y;
        end
        return r;
    endfunction

    function automatic rot_t rot_step(input rot_t v, input int i);
        rot_t r;
        logic signed [RX_W-1:0]  xs;
        logic signed [RX_W-1:0]  ys;
        logic signed [ANG_W-1:0] a;
        xs = v.x >>> i;
        ys = v.y >>> i;
        a  = ANG_W'(signed'({1'b0, atan_ang(i)}));
        if (v.a >= 0)
        begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.a = v.a - a;
        end
        else
        begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.a = v.a + a;
        end
        return r;
    endfunction

    // one result bit of the restoring square root
    function automatic sq_t sq_step(input sq_t q, input int k);
        sq_t r;
        logic [SQ_RW-1:0] bitv;
        logic [SQ_RW-1:0] sum;
        bitv = SQ_RW'(1) << (2 * (SQ_STEPS - 1 - k));
        sum  = q.res + bitv;
        if ({1'b0, q.rem} >= sum)
        begin
            r.rem = q.rem - sum[SQ_W-1:0];
            r.res = (q.res >> 1) + bitv;
        end
        else
        begin
            r.rem = q.rem;
            r.res = q.res >> 1;
        end
        return r;
    endfunction

endpackage

[hw/rtl/qecc_pose_if.sv]
interface qecc_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

[hw/rtl/qecc_cam_if.sv]
interface qecc_cam_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;

    modport source (output valid, roll, pitch, yaw, eye_x, eye_y, eye_z, input ready);
    modport sink (input valid, roll, pitch, yaw, eye_x, eye_y, eye_z, output ready);
endinterface

[hw/rtl/quaternion_euler_chase_camera.sv]
// Chase-camera placement from a pose: roll, pitch and yaw (ZYX) as 16-bit binary angles
// and a camera eye follow_distance behind the pose along its yaw. The block takes one
// pose per clock, unless a held result stalls it, through three product/setup stages,
// a 31-stage square root for the pitch cosine, the vectoring CORDIC, two angle stages,
// the rotation CORDIC and the output register. A held result freezes the whole pipeline,
// so input ready drops only while a finished result waits. Registers are to be written
// over the APB port while idle; the block itself does not enforce this.
module quaternion_euler_chase_camera
    import qecc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    qecc_pose_if.sink          pose,
    qecc_cam_if.source         view,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NS = CORDIC_STAGES;

    logic en;
    logic vout_reg;

    assign en         = !vout_reg || view.ready;
    assign pose.ready = en;
    assign pready     = 1'b1;

    // configuration
    logic [23:0]        fd_reg;
    logic signed [31:0] min_h_reg;
    logic signed [31:0] fb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_reg    <= 24'd524288;
            min_h_reg <= 32'sd65536;
            fb_reg    <= 32'sd131072;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_FOLLOW:   fd_reg    <= pwdata[23:0];
                REG_MIN_H:    min_h_reg <= pwdata;
                REG_FALLBACK: fb_reg    <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_FOLLOW:   prdata = {8'd0, fd_reg};
            REG_MIN_H:    prdata = min_h_reg;
            REG_FALLBACK: prdata = fb_reg;
            default:      prdata = '0;
        endcase
    end

    // stage 1: quaternion products
    logic  v1_reg;
    prod_t p1_reg;
    pos_t  pos1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= pose.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg.zy  <= pose.quat_z * pose.quat_y;
            p1_reg.wx  <= pose.quat_w * pose.quat_x;
            p1_reg.xx  <= pose.quat_x * pose.quat_x;
            p1_reg.yy  <= pose.quat_y * pose.quat_y;
            p1_reg.zw  <= pose.quat_z * pose.quat_w;
            p1_reg.xy  <= pose.quat_x * pose.quat_y;
            p1_reg.zz  <= pose.quat_z * pose.quat_z;
            p1_reg.yw  <= pose.quat_y * pose.quat_w;
            p1_reg.zx  <= pose.quat_z * pose.quat_x;
            pos1_reg.x <= pose.pos_x;
            pos1_reg.y <= pose.pos_y;
            pos1_reg.z <= pose.pos_z;
        end
    end

    // stage 2: atan2 operands and clamped asin argument
    logic               v2_reg;
    vec_t               rv2_reg, yv2_reg, rv2_next, yv2_next;
    logic signed [31:0] s2_reg, s2_next;
    logic signed [VX_W-1:0] s_raw;
    pos_t               pos2_reg;

    always_comb
    begin
        rv2_next.y = (VX_W'(p1_reg.zy) + VX_W'(p1_reg.wx)) <<< 1;
        rv2_next.x = ONE_Q30 - ((VX_W'(p1_reg.xx) + VX_W'(p1_reg.yy)) <<< 1);
        rv2_next.z = '0;
        yv2_next.y = (VX_W'(p1_reg.zw) + VX_W'(p1_reg.xy)) <<< 1;
        yv2_next.x = ONE_Q30 - ((VX_W'(p1_reg.yy) + VX_W'(p1_reg.zz)) <<< 1);
        yv2_next.z = '0;
        s_raw      = (VX_W'(p1_reg.yw) - VX_W'(p1_reg.zx)) <<< 1;
        if (s_raw > ONE_Q30)
            s2_next = 32'(ONE_Q30);
        else if (s_raw < -ONE_Q30)
            s2_next = 32'(-ONE_Q30);
        else
            s2_next = 32'(s_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rv2_reg  <= rv2_next;
            yv2_reg  <= yv2_next;
            s2_reg   <= s2_next;
            pos2_reg <= pos1_reg;
        end
    end

    // stage 3: pre-rotation and square-root operand 2^60 - s^2
    logic               v3_reg;
    sqc_t               c3_reg;
    sq_t                q3_reg;
    logic signed [63:0] ss;

    assign ss = s2_reg * s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg.pos <= pos2_reg;
            c3_reg.rv  <= vec_prerot(rv2_reg);
            c3_reg.yv  <= vec_prerot(yv2_reg);
            c3_reg.s   <= s2_reg;
            q3_reg.rem <= (SQ_W'(1) << 60) - ss[SQ_W-1:0];
            q3_reg.res <= '0;
        end
    end

    // square root, one result bit per stage
    logic [SQ_STEPS-1:0] vsq_reg;
    sq_t                 sq_reg [SQ_STEPS];
    sqc_t                csq_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        sq_t  q_in;
        sqc_t c_in;
        logic v_in;
        if (k == 0)
        begin : g_first
            assign q_in = q3_reg;
            assign c_in = c3_reg;
            assign v_in = v3_reg;
        end
        else
        begin : g_next
            assign q_in = sq_reg[k-1];
            assign c_in = csq_reg[k-1];
            assign v_in = vsq_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vsq_reg[k] <= 1'b0;
            else if (en)
                vsq_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k]  <= sq_step(q_in, k);
                csq_reg[k] <= c_in;
            end
        end
    end

    // vectoring cordic: roll, yaw and pitch lanes side by side
    logic [NS-1:0] vcv_reg;
    vec_t          cr_reg [NS];
    vec_t          cy_reg [NS];
    vec_t          cp_reg [NS];
    pos_t          pcv_reg [NS];
    vec_t          pitch_init;

    always_comb
    begin
        pitch_init.x = VX_W'({1'b0, sq_reg[SQ_STEPS-1].res[30:0]});
        pitch_init.y = VX_W'(csq_reg[SQ_STEPS-1].s);
        pitch_init.z = '0;
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_vec
        vec_t r_in, y_in, p_in;
        pos_t pos_in;
        logic v_in;
        if (k == 0)
        begin : g_first
            assign r_in   = csq_reg[SQ_STEPS-1].rv;
            assign y_in   = csq_reg[SQ_STEPS-1].yv;
            assign p_in   = pitch_init;
            assign pos_in = csq_reg[SQ_STEPS-1].pos;
            assign v_in   = vsq_reg[SQ_STEPS-1];
        end
        else
        begin : g_next
            assign r_in   = cr_reg[k-1];
            assign y_in   = cy_reg[k-1];
            assign p_in   = cp_reg[k-1];
            assign pos_in = pcv_reg[k-1];
            assign v_in   = vcv_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vcv_reg[k] <= 1'b0;
            else if (en)
                vcv_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cr_reg[k]  <= vec_step(r_in, k);
                cy_reg[k]  <= vec_step(y_in, k);
                cp_reg[k]  <= vec_step(p_in, k);
                pcv_reg[k] <= pos_in;
            end
        end
    end

    // round angles to 16 bits, clamp pitch to a quarter turn, scale follow distance by the cordic gain
    logic                    vrd_reg;
    logic signed [15:0]      roll_rd_reg, pitch_rd_reg, yaw_rd_reg, pitch_rd_next;
    logic signed [RX_W-1:0]  cx0_rd_reg;
    pos_t                    pos_rd_reg;
    logic signed [ANG_W-1:0] zr, zy, zp;
    logic [53:0]             fd_scaled;

    always_comb
    begin
        zr        = cr_reg[NS-1].z + ANG_W'(32768);
        zy        = cy_reg[NS-1].z + ANG_W'(32768);
        zp        = (cp_reg[NS-1].z + ANG_W'(32768)) >>> 16;
        fd_scaled = fd_reg * KINV_Q30;
        if (zp > ANG_W'(16384))
            pitch_rd_next = 16'sd16384;
        else if (zp < -ANG_W'(16384))
            pitch_rd_next = -16'sd16384;
        else
            pitch_rd_next = zp[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vrd_reg <= 1'b0;
        else if (en)
            vrd_reg <= vcv_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_rd_reg  <= zr[31:16];
            yaw_rd_reg   <= zy[31:16];
            pitch_rd_reg <= pitch_rd_next;
            cx0_rd_reg   <= RX_W'(fd_scaled >> 14);
            pos_rd_reg   <= pcv_reg[NS-1];
        end
    end

    // fold yaw into the right half-plane
    logic                    vpr_reg;
    rot_t                    rpr_reg, rpr_next;
    logic signed [15:0]      roll_pr_reg, pitch_pr_reg, yaw_pr_reg;
    pos_t                    pos_pr_reg;
    logic signed [ANG_W-1:0] ang0;

    always_comb
    begin
        ang0       = ANG_W'(yaw_rd_reg) <<< 16;
        rpr_next.y = '0;
        rpr_next.x = cx0_rd_reg;
        rpr_next.a = ang0;
        if (ang0 > ANG_HALF_PI)
        begin
            rpr_next.a = ang0 - ANG_PI;
            rpr_next.x = -cx0_rd_reg;
        end
        else if (ang0 < -ANG_HALF_PI)
        begin
            rpr_next.a = ang0 + ANG_PI;
            rpr_next.x = -cx0_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpr_reg <= 1'b0;
        else if (en)
            vpr_reg <= vrd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rpr_reg      <= rpr_next;
            roll_pr_reg  <= roll_rd_reg;
            pitch_pr_reg <= pitch_rd_reg;
            yaw_pr_reg   <= yaw_rd_reg;
            pos_pr_reg   <= pos_rd_reg;
        end
    end

    // rotation cordic for the camera offset
    logic [NS-1:0]      vrt_reg;
    rot_t               rt_reg [NS];
    logic [47:0]        ang_rt_reg [NS];
    pos_t               prt_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_rot
        rot_t        r_in;
        logic [47:0] a_in;
        pos_t        pos_in;
        logic        v_in;
        if (k == 0)
        begin : g_first
            assign r_in   = rpr_reg;
            assign a_in   = {roll_pr_reg, pitch_pr_reg, yaw_pr_reg};
            assign pos_in = pos_pr_reg;
            assign v_in   = vpr_reg;
        end
        else
        begin : g_next
            assign r_in   = rt_reg[k-1];
            assign a_in   = ang_rt_reg[k-1];
            assign pos_in = prt_reg[k-1];
            assign v_in   = vrt_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vrt_reg[k] <= 1'b0;
            else if (en)
                vrt_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_reg[k]     <= rot_step(r_in, k);
                ang_rt_reg[k] <= a_in;
                prt_reg[k]    <= pos_in;
            end
        end
    end

    // output register: round offsets, subtract, saturate, pick height
    localparam logic signed [RX_W-1:0] MAX32 = RX_W'(64'sd2147483647);
    localparam logic signed [RX_W-1:0] MIN32 = RX_W'(-64'sd2147483648);

    logic signed [RX_W-1:0] ox, oy, ex, ey;
    logic signed [31:0]     eye_x_next, eye_y_next, eye_z_next;
    logic signed [31:0]     eye_x_reg, eye_y_reg, eye_z_reg;
    logic signed [15:0]     roll_o_reg, pitch_o_reg, yaw_o_reg;
    pos_t                   pl;

    always_comb
    begin
        pl = prt_reg[NS-1];
        ox = (rt_reg[NS-1].x + RX_W'(32768)) >>> 16;
        oy = (rt_reg[NS-1].y + RX_W'(32768)) >>> 16;
        ex = RX_W'(pl.x) - ox;
        ey = RX_W'(pl.y) - oy;
        if (ex > MAX32)
            eye_x_next = 32'sh7fffffff;
        else if (ex < MIN32)
            eye_x_next = 32'sh80000000;
        else
            eye_x_next = ex[31:0];
        if (ey > MAX32)
            eye_y_next = 32'sh7fffffff;
        else if (ey < MIN32)
            eye_y_next = 32'sh80000000;
        else
            eye_y_next = ey[31:0];
        eye_z_next = (pl.z < min_h_reg) ? fb_reg : pl.z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else if (en)
            vout_reg <= vrt_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_o_reg  <= ang_rt_reg[NS-1][47:32];
            pitch_o_reg <= ang_rt_reg[NS-1][31:16];
            yaw_o_reg   <= ang_rt_reg[NS-1][15:0];
            eye_x_reg   <= eye_x_next;
            eye_y_reg   <= eye_y_next;
            eye_z_reg   <= eye_z_next;
        end
    end

    assign view.valid = vout_reg;
    assign view.roll  = roll_o_reg;
    assign view.pitch = pitch_o_reg;
    assign view.yaw   = yaw_o_reg;
    assign view.eye_x = eye_x_reg;
    assign view.eye_y = eye_y_reg;
    assign view.eye_z = eye_z_reg;

endmodule

[hw/rtl/qecc_chk.sv]
`include "assert_macros.svh"

module qecc_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] pitch,
    input logic signed [15:0] roll,
    input logic signed [31:0] eye_x
);

    // a held result stalls the whole pipe
    `QECC_ASSERT_IMPLY(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
    // with nothing waiting at the output, a new request is always taken
    `QECC_ASSERT_IMPLY(a_free_takes_in, !out_valid, in_ready)
    `QECC_ASSERT_IMPLY(a_pitch_range, out_valid, (pitch >= -16'sd16384) && (pitch <= 16'sd16384))
    `QECC_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(roll) && $stable(eye_x))

endmodule

bind quaternion_euler_chase_camera qecc_chk u_qecc_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pose.ready),
    .out_valid (view.valid),
    .out_ready (view.ready),
    .pitch     (view.pitch),
    .roll      (view.roll),
    .eye_x     (view.eye_x)
);
